// ===== rtl/core/output_current_limit_checker_unit_assert.svh =====
// Assertion macros for the output current limit checker.
`ifndef OUTPUT_CURRENT_LIMIT_CHECKER_UNIT_ASSERT_SVH
`define OUTPUT_CURRENT_LIMIT_CHECKER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define OCLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define OCLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/oclc_pkg.sv =====
package oclc_pkg;

  localparam int TABLE_POINTS_DEF = 9;

  localparam int VOLT_W   = 10;
  localparam int CURR_W   = 16;
  localparam int IDX_IN_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VERDICT_W  = 3;

  localparam logic [VOLT_W-1:0] MIN_VOLTAGE_RST = 10'd250;
  localparam logic [VOLT_W-1:0] MAX_VOLTAGE_RST = 10'd560;

  localparam logic [CFG_IDX_W-1:0] REG_PROFILE_READY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_VOLT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_CURRENT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HW_MAX_CURRENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATED_POWER    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_TOL      = 3'd7;

  localparam logic [VERDICT_W-1:0] VERDICT_VALID      = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INCOMPLETE = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_VOLT_BAD   = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_ZERO       = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_IV_CAP     = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_POWER      = 3'd5;
  localparam logic [VERDICT_W-1:0] VERDICT_HW_MAX     = 3'd6;
  localparam logic [VERDICT_W-1:0] VERDICT_FAIL       = 3'd7;

  typedef struct packed {
    logic                req_type;
    logic [IDX_IN_W-1:0] entry_index;
    logic [VOLT_W-1:0]   entry_voltage;
    logic [CURR_W-1:0]   entry_current;
    logic [VOLT_W-1:0]   bound_voltage;
    logic [CURR_W-1:0]   test_current;
  } in_item_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [CURR_W-1:0]    applied_cap;
  } out_item_t;

endpackage

// ===== rtl/core/output_current_limit_checker_unit.sv =====
// Output current limit checker.
// Input channel in_valid/in_ready/in_data carries table writes (req_type 1) and
// current checks (req_type 0). Output channel out_valid/out_ready/out_data
// gives one verdict and applied cap per transfer in. Configuration registers
// are written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. A table
// write goes from idle to the done state and then to the output register. A
// check walks the breakpoint table one entry a cycle, stopping at the first
// entry above the voltage, then uses one shared 16x16 multiplier twice (power
// limit, then requested power), decides, and passes through the done state.
// in_ready is high only in the idle state; one item is in work at a time,
// so a new item is taken only after the last result has left the done state.
// The output register holds a finished result while out_ready is low; the
// next item may be taken meanwhile, and its result waits in the sequencer
// until the output register is free.
// Synchronous reset clears the table, loads register reset values, empties
// the output register and returns the sequencer to idle.
module output_current_limit_checker_unit #(
  parameter int TABLE_POINTS = oclc_pkg::TABLE_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  oclc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output oclc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [oclc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [oclc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import oclc_pkg::*;

  localparam int IDX_W   = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
  localparam int LIMIT_W = 25;
  localparam int PROD_W  = 2 * CURR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL_LIM,
    ST_MUL_PWR,
    ST_DECIDE,
    ST_DONE
  } state_t;

  state_t st;

  logic [VOLT_W-1:0] break_voltage [TABLE_POINTS];
  logic [CURR_W-1:0] break_current [TABLE_POINTS];

  logic              profile_ready;
  logic [VOLT_W-1:0] min_voltage;
  logic [VOLT_W-1:0] max_voltage;
  logic [VOLT_W-1:0] special_voltage;
  logic [CURR_W-1:0] fail_current;
  logic [CURR_W-1:0] hardware_max_current;
  logic [VOLT_W-1:0] rated_power;
  logic [VOLT_W-1:0] power_tolerance;

  logic [VOLT_W-1:0]    volt;
  logic [CURR_W-1:0]    cur;
  logic [CURR_W-1:0]    cap;
  logic [IDX_W-1:0]     idx;
  logic [PROD_W-1:0]    prod;
  logic [LIMIT_W-1:0]   limit;
  logic [VERDICT_W-1:0] res_verdict;

  logic [CURR_W-1:0]    mul_a;
  logic [CURR_W-1:0]    mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [13:0]          rated_x10;
  logic [10:0]          tol_scale;
  logic [VERDICT_W-1:0] verdict_next;
  logic                 in_xfer;
  logic                 idx_last;
  logic                 entry_in_range;
  logic                 done_go;
  logic                 out_is_power;

  assign in_ready       = (st == ST_IDLE);
  assign in_xfer        = in_valid && in_ready;
  assign idx_last       = (idx == IDX_W'(TABLE_POINTS - 1));
  assign entry_in_range = ({2'b00, in_data.entry_index} < 6'(TABLE_POINTS));
  assign done_go        = (st == ST_DONE) && (!out_valid || out_ready);
  assign out_is_power   = out_valid && (out_data.verdict == VERDICT_POWER);

  assign rated_x10 = {1'b0, rated_power, 3'b000} + {3'b000, rated_power, 1'b0};
  assign tol_scale = 11'd1000 + {1'b0, power_tolerance};

  always_comb begin
    if (st == ST_MUL_LIM) begin
      mul_a = {2'b00, rated_x10};
      mul_b = {5'b00000, tol_scale};
    end else begin
      mul_a = cur;
      mul_b = {6'b000000, volt};
    end
    mul_p = {{CURR_W{1'b0}}, mul_a} * {{CURR_W{1'b0}}, mul_b};
  end

  always_comb begin
    if (!profile_ready) begin
      verdict_next = VERDICT_INCOMPLETE;
    end else if (volt < min_voltage || volt > max_voltage || volt == special_voltage) begin
      verdict_next = VERDICT_VOLT_BAD;
    end else if (cur == '0) begin
      verdict_next = VERDICT_ZERO;
    end else if (cur >= fail_current) begin
      verdict_next = VERDICT_FAIL;
    end else if (cur > hardware_max_current) begin
      verdict_next = VERDICT_HW_MAX;
    end else if (cap == '0 || cur > cap) begin
      verdict_next = VERDICT_IV_CAP;
    end else if (prod > {{(PROD_W-LIMIT_W){1'b0}}, limit}) begin
      verdict_next = VERDICT_POWER;
    end else begin
      verdict_next = VERDICT_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      profile_ready        <= 1'b0;
      min_voltage          <= MIN_VOLTAGE_RST;
      max_voltage          <= MAX_VOLTAGE_RST;
      special_voltage      <= '0;
      fail_current         <= '0;
      hardware_max_current <= '0;
      rated_power          <= '0;
      power_tolerance      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROFILE_READY:  profile_ready        <= cfg_data[0];
        REG_MIN_VOLTAGE:    min_voltage          <= cfg_data[VOLT_W-1:0];
        REG_MAX_VOLTAGE:    max_voltage          <= cfg_data[VOLT_W-1:0];
        REG_SPECIAL_VOLT:   special_voltage      <= cfg_data[VOLT_W-1:0];
        REG_FAIL_CURRENT:   fail_current         <= cfg_data[CURR_W-1:0];
        REG_HW_MAX_CURRENT: hardware_max_current <= cfg_data[CURR_W-1:0];
        REG_RATED_POWER:    rated_power          <= cfg_data[VOLT_W-1:0];
        REG_POWER_TOL:      power_tolerance      <= cfg_data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_POINTS; i++) begin
        break_voltage[i] <= '0;
        break_current[i] <= '0;
      end
    end else if (in_xfer && in_data.req_type && entry_in_range) begin
      for (int i = 0; i < TABLE_POINTS; i++) begin
        if ({2'b00, in_data.entry_index} == 6'(i)) begin
          break_voltage[i] <= in_data.entry_voltage;
          break_current[i] <= in_data.entry_current;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && st != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (in_xfer) begin
            volt <= in_data.bound_voltage;
            cur  <= in_data.test_current;
            cap  <= '0;
            idx  <= '0;
            if (in_data.req_type) begin
              res_verdict <= VERDICT_VALID;
              st          <= ST_DONE;
            end else begin
              st <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (volt >= break_voltage[idx]) begin
            cap <= break_current[idx];
            if (idx_last) begin
              st <= ST_MUL_LIM;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            st <= ST_MUL_LIM;
          end
        end
        ST_MUL_LIM: begin
          prod <= mul_p;
          st   <= ST_MUL_PWR;
        end
        ST_MUL_PWR: begin
          limit <= prod[LIMIT_W-1:0];
          prod  <= mul_p;
          st    <= ST_DECIDE;
        end
        ST_DECIDE: begin
          res_verdict <= verdict_next;
          st          <= ST_DONE;
        end
        ST_DONE: begin
          if (done_go) begin
            out_valid            <= 1'b1;
            out_data.verdict     <= res_verdict;
            out_data.applied_cap <= cap;
            st                   <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

`include "output_current_limit_checker_unit_assert.svh"

  `OCLC_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready, "input taken while busy")
  `OCLC_ASSERT_NOW(a_walk_range, st == ST_WALK, idx <= IDX_W'(TABLE_POINTS - 1), "walk past end")
  `OCLC_ASSERT_NOW(a_power_cap, out_is_power, out_data.applied_cap != '0, "power without cap")
  `OCLC_ASSERT_NEXT(a_done_to_idle, done_go, out_valid && st == ST_IDLE, "result not delivered")

endmodule
